### hw/rtl/c80x_pkg.sv
// Package for the 8080 subset executor: state codes, command and status structs.
// No dependencies.
package c80x_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_FOP,
    ST_WOP,
    ST_FB1,
    ST_WB1,
    ST_FB2,
    ST_WB2,
    ST_MEM1,
    ST_WMEM1,
    ST_MEM2,
    ST_WMEM2,
    ST_EXEC,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load_wr;
    logic rd_pc;
    logic rd_pc1;
    logic rd_pc2;
    logic cap_op;
    logic cap_b1;
    logic cap_b2;
    logic mem1;
    logic mem2;
    logic cap_m1;
    logic cap_m2;
    logic exec;
  } cmd_t;

  typedef struct packed {
    logic halted;
    logic need_mem2;
  } stat_t;

  localparam logic [7:0] OP_DAA = 8'h27;
  localparam logic [7:0] OP_HLT = 8'h76;
  localparam logic [7:0] OP_SHLD = 8'h22;
  localparam logic [7:0] OP_LHLD = 8'h2A;
  localparam logic [7:0] OP_STA = 8'h32;
  localparam logic [7:0] OP_LDA = 8'h3A;
  localparam logic [7:0] OP_STAXB = 8'h02;
  localparam logic [7:0] OP_STAXD = 8'h12;
  localparam logic [7:0] OP_LDAXB = 8'h0A;
  localparam logic [7:0] OP_LDAXD = 8'h1A;
  localparam logic [7:0] OP_RLC = 8'h07;
  localparam logic [7:0] OP_RRC = 8'h0F;
  localparam logic [7:0] OP_RAL = 8'h17;
  localparam logic [7:0] OP_RAR = 8'h1F;
  localparam logic [7:0] OP_CMA = 8'h2F;
  localparam logic [7:0] OP_STC = 8'h37;
  localparam logic [2:0] R_M = 3'd6;

endpackage

### hw/rtl/c80x_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module c80x_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

### hw/rtl/c80x_ctrl.sv
// Controller state machine for the executor.
// Depends on c80x_pkg.
module c80x_ctrl import c80x_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  logic  in_kind,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_kind) state_nxt = ST_LOAD;
          else if (stat.halted) state_nxt = ST_OUT;
          else state_nxt = ST_FOP;
        end
      end
      ST_LOAD: state_nxt = ST_OUT;
      ST_FOP: state_nxt = ST_WOP;
      ST_WOP: state_nxt = ST_FB1;
      ST_FB1: state_nxt = ST_WB1;
      ST_WB1: state_nxt = ST_FB2;
      ST_FB2: state_nxt = ST_WB2;
      ST_WB2: state_nxt = ST_MEM1;
      ST_MEM1: state_nxt = ST_WMEM1;
      ST_WMEM1: state_nxt = stat.need_mem2 ? ST_MEM2 : ST_EXEC;
      ST_MEM2: state_nxt = ST_WMEM2;
      ST_WMEM2: state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = ST_OUT;
      ST_OUT: if (out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = (state_r == ST_IDLE);
    out_valid = (state_r == ST_OUT);
    unique case (state_r)
      ST_LOAD: cmd.load_wr = 1'b1;
      ST_FOP: cmd.rd_pc = 1'b1;
      ST_WOP: cmd.cap_op = 1'b1;
      ST_FB1: cmd.rd_pc1 = 1'b1;
      ST_WB1: cmd.cap_b1 = 1'b1;
      ST_FB2: cmd.rd_pc2 = 1'b1;
      ST_WB2: cmd.cap_b2 = 1'b1;
      ST_MEM1: cmd.mem1 = 1'b1;
      ST_WMEM1: cmd.cap_m1 = 1'b1;
      ST_MEM2: cmd.mem2 = 1'b1;
      ST_WMEM2: cmd.cap_m2 = 1'b1;
      ST_EXEC: cmd.exec = 1'b1;
      default: cmd = '0;
    endcase
  end
endmodule

### hw/rtl/c80x_dp.sv
// Datapath: register file, flags, memory port and instruction execution.
// Depends on c80x_pkg and c80x_ram.
module c80x_dp import c80x_pkg::*; #(
  parameter int MEM_DEPTH = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [15:0] in_load_address,
  input  logic [7:0]  in_load_data,
  input  cmd_t        cmd,
  output stat_t       stat,
  output logic [7:0]  a_r,
  output logic [7:0]  b_r,
  output logic [7:0]  c_r,
  output logic [7:0]  d_r,
  output logic [7:0]  e_r,
  output logic [7:0]  h_r,
  output logic [7:0]  l_r,
  output logic [15:0] sp_r,
  output logic [15:0] pc_r,
  output logic [3:0]  flag_r,
  output logic        halt_r
);
  localparam int AW = $clog2(MEM_DEPTH);

  logic [15:0] ld_addr_r;
  logic [7:0]  ld_data_r, op_r, b1_r, b2_r, m1_r, m2_r;
  logic        mem_we;
  logic [15:0] mem_addr16;
  logic [7:0]  mem_wdata, mem_rdata;

  logic [15:0] imm, hl, bc, de, imm1;
  logic [2:0]  rd, rs;
  logic [1:0]  rp;
  logic        is_mov, is_m_src, is_m_dst, is_incm;
  logic        bad_op;

  assign imm  = {b2_r, b1_r};
  assign imm1 = imm + 16'd1;
  assign hl   = {h_r, l_r};
  assign bc   = {b_r, c_r};
  assign de   = {d_r, e_r};
  assign rd   = op_r[5:3];
  assign rs   = op_r[2:0];
  assign rp   = op_r[5:4];
  assign is_mov = op_r[7:6] == 2'b01 && op_r != OP_HLT;
  assign is_m_src = is_mov && rs == R_M;
  assign is_m_dst = is_mov && rd == R_M;
  assign is_incm = op_r[7:6] == 2'b00 && rd == R_M &&
                   (op_r[2:0] == 3'd4 || op_r[2:0] == 3'd5 || op_r[2:0] == 3'd6);
  assign bad_op = op_r == OP_DAA || op_r[7];

  always_comb begin
    stat = '0;
    stat.halted    = halt_r;
    stat.need_mem2 = op_r == OP_SHLD || op_r == OP_LHLD;
  end

  function automatic logic [7:0] src_reg(input logic [2:0] s);
    logic [7:0] v;
    unique case (s)
      3'd0: v = b_r;
      3'd1: v = c_r;
      3'd2: v = d_r;
      3'd3: v = e_r;
      3'd4: v = h_r;
      3'd5: v = l_r;
      3'd6: v = m1_r;
      default: v = a_r;
    endcase
    return v;
  endfunction

  // First data access: write for stores, read for loads and read of M for read-modify-write.
  logic        m1_wr;
  logic [15:0] m1_addr;
  logic [7:0]  m1_data;
  always_comb begin
    m1_wr = 1'b0;
    m1_addr = hl;
    m1_data = a_r;
    if (!bad_op) begin
      priority case (1'b1)
        op_r == OP_STAXB: begin m1_wr = 1'b1; m1_addr = bc; end
        op_r == OP_STAXD: begin m1_wr = 1'b1; m1_addr = de; end
        op_r == OP_LDAXB: m1_addr = bc;
        op_r == OP_LDAXD: m1_addr = de;
        op_r == OP_SHLD: begin m1_wr = 1'b1; m1_addr = imm; m1_data = l_r; end
        op_r == OP_LHLD: m1_addr = imm;
        op_r == OP_STA: begin m1_wr = 1'b1; m1_addr = imm; end
        op_r == OP_LDA: m1_addr = imm;
        op_r[7:6] == 2'b00 && op_r[2:0] == 3'd6 && rd == R_M: begin
          m1_wr = 1'b1; m1_data = b1_r;
        end
        is_m_dst && !is_m_src: begin m1_wr = 1'b1; m1_data = src_reg(rs); end
        default: m1_wr = 1'b0;
      endcase
    end
  end

  // INR/DCR on M writes back to HL in the execute step.
  logic [7:0] incdec;
  assign incdec = op_r[0] ? src_reg(rd) - 8'd1 : src_reg(rd) + 8'd1;

  always_comb begin
    mem_we = 1'b0;
    mem_addr16 = pc_r;
    mem_wdata = ld_data_r;
    priority case (1'b1)
      cmd.load_wr: begin mem_we = 1'b1; mem_addr16 = ld_addr_r; end
      cmd.rd_pc: mem_addr16 = pc_r;
      cmd.rd_pc1: mem_addr16 = pc_r + 16'd1;
      cmd.rd_pc2: mem_addr16 = pc_r + 16'd2;
      cmd.mem1: begin mem_we = m1_wr; mem_addr16 = m1_addr; mem_wdata = m1_data; end
      cmd.mem2: begin
        mem_addr16 = imm1;
        mem_we = op_r == OP_SHLD;
        mem_wdata = h_r;
      end
      cmd.exec: begin
        mem_we = is_incm && op_r[2:0] != 3'd6 && !bad_op;
        mem_addr16 = hl;
        mem_wdata = incdec;
      end
      default: mem_we = 1'b0;
    endcase
  end

  c80x_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr16[AW-1:0]),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ld_addr_r <= in_load_address;
      ld_data_r <= in_load_data;
    end
    if (cmd.cap_op) op_r <= mem_rdata;
    if (cmd.cap_b1) b1_r <= mem_rdata;
    if (cmd.cap_b2) b2_r <= mem_rdata;
    if (cmd.cap_m1) m1_r <= mem_rdata;
    if (cmd.cap_m2) m2_r <= mem_rdata;
  end

  function automatic logic [3:0] szp(input logic [7:0] v, input logic cy);
    return {v[7], v == 8'd0, ~^v, cy};
  endfunction

  // Execution.
  logic [7:0]  a_nxt, b_nxt, c_nxt, d_nxt, e_nxt, h_nxt, l_nxt;
  logic [15:0] sp_nxt, pc_nxt, pv, pinc;
  logic [16:0] dsum;
  logic [3:0]  flag_nxt;
  logic        halt_nxt;
  logic [7:0]  wv;
  logic        wr_reg;

  always_comb begin
    unique case (rp)
      2'd0: pv = bc;
      2'd1: pv = de;
      2'd2: pv = hl;
      default: pv = sp_r;
    endcase
  end
  assign pinc = op_r[3] ? pv - 16'd1 : pv + 16'd1;
  assign dsum = {1'b0, hl} + {1'b0, pv};

  always_comb begin
    a_nxt = a_r; b_nxt = b_r; c_nxt = c_r; d_nxt = d_r; e_nxt = e_r;
    h_nxt = h_r; l_nxt = l_r; sp_nxt = sp_r; pc_nxt = pc_r + 16'd1;
    flag_nxt = flag_r; halt_nxt = halt_r;
    wr_reg = 1'b0; wv = 8'd0;
    if (bad_op) begin
      halt_nxt = 1'b1;
      pc_nxt = pc_r;
    end else if (op_r[6]) begin
      wr_reg = op_r != OP_HLT; wv = src_reg(rs);
    end else begin
      unique case (op_r[2:0])
        3'd1: begin
          if (op_r[3]) begin
            h_nxt = dsum[15:8]; l_nxt = dsum[7:0]; flag_nxt[0] = dsum[16];
          end else begin
            pc_nxt = pc_r + 16'd3;
            unique case (rp)
              2'd0: begin b_nxt = b2_r; c_nxt = b1_r; end
              2'd1: begin d_nxt = b2_r; e_nxt = b1_r; end
              2'd2: begin h_nxt = b2_r; l_nxt = b1_r; end
              default: sp_nxt = imm;
            endcase
          end
        end
        3'd2: begin
          if (op_r == OP_LDAXB || op_r == OP_LDAXD) a_nxt = m1_r;
          if (op_r == OP_LDA) a_nxt = m1_r;
          if (op_r == OP_LHLD) begin l_nxt = m1_r; h_nxt = m2_r; end
          if (op_r[5]) pc_nxt = pc_r + 16'd3;
        end
        3'd3: begin
          unique case (rp)
            2'd0: begin b_nxt = pinc[15:8]; c_nxt = pinc[7:0]; end
            2'd1: begin d_nxt = pinc[15:8]; e_nxt = pinc[7:0]; end
            2'd2: begin h_nxt = pinc[15:8]; l_nxt = pinc[7:0]; end
            default: sp_nxt = pinc;
          endcase
        end
        3'd4, 3'd5: begin
          wr_reg = 1'b1; wv = incdec; flag_nxt = szp(incdec, flag_r[0]);
        end
        3'd6: begin
          wr_reg = 1'b1; wv = b1_r; pc_nxt = pc_r + 16'd2;
        end
        3'd7: begin
          unique case (op_r)
            OP_RLC: begin a_nxt = {a_r[6:0], a_r[7]}; flag_nxt[0] = a_r[7]; end
            OP_RRC: begin a_nxt = {a_r[0], a_r[7:1]}; flag_nxt[0] = a_r[0]; end
            OP_RAL: begin a_nxt = {a_r[6:0], flag_r[0]}; flag_nxt[0] = a_r[7]; end
            OP_RAR: begin a_nxt = {flag_r[0], a_r[7:1]}; flag_nxt[0] = a_r[0]; end
            OP_CMA: a_nxt = ~a_r;
            OP_STC: flag_nxt[0] = 1'b1;
            default: flag_nxt[0] = ~flag_r[0];
          endcase
        end
        default: pc_nxt = pc_r + 16'd1;
      endcase
    end
    if (wr_reg) begin
      unique case (rd)
        3'd0: b_nxt = wv;
        3'd1: c_nxt = wv;
        3'd2: d_nxt = wv;
        3'd3: e_nxt = wv;
        3'd4: h_nxt = wv;
        3'd5: l_nxt = wv;
        3'd6: a_nxt = a_nxt;
        default: a_nxt = wv;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r <= '0; b_r <= '0; c_r <= '0; d_r <= '0; e_r <= '0; h_r <= '0; l_r <= '0;
      sp_r <= '0; pc_r <= '0; flag_r <= '0; halt_r <= 1'b0;
    end else if (cmd.exec) begin
      a_r <= a_nxt; b_r <= b_nxt; c_r <= c_nxt; d_r <= d_nxt; e_r <= e_nxt;
      h_r <= h_nxt; l_r <= l_nxt; sp_r <= sp_nxt; pc_r <= pc_nxt;
      flag_r <= flag_nxt; halt_r <= halt_nxt;
    end
  end
endmodule

### hw/rtl/cpu8080_subset_executor.sv
// Top level of the 8080 subset executor: controller plus datapath.
// Depends on c80x_pkg, c80x_ctrl and c80x_dp.
//
//   channel | ports                         | direction
//   in      | in_valid/in_ready, payload    | item in (step or memory load)
//   out     | out_valid/out_ready, payload  | item out (machine state)
//
// A load item writes memory and then gives its result; a step item goes in turn
// through the single memory port: opcode, two immediates and one or two data
// accesses, each with a registered read. A halted step goes straight to its result.
// Reset clears all registers and flags; memory is undefined until written.
// A stalled result holds until out_ready; no new item is taken meanwhile.
module cpu8080_subset_executor import c80x_pkg::*; #(
  parameter int MEM_DEPTH = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [15:0] in_load_address,
  input  logic [7:0]  in_load_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_a_out,
  output logic [7:0]  out_b_out,
  output logic [7:0]  out_c_out,
  output logic [7:0]  out_d_out,
  output logic [7:0]  out_e_out,
  output logic [7:0]  out_h_out,
  output logic [7:0]  out_l_out,
  output logic [15:0] out_sp_out,
  output logic [15:0] out_pc_out,
  output logic [3:0]  out_flag_bits,
  output logic        out_halted_error
);
  cmd_t  cmd;
  stat_t stat;

  c80x_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_kind, .out_valid, .out_ready,
    .stat, .cmd
  );

  c80x_dp #(.MEM_DEPTH(MEM_DEPTH)) u_dp (
    .clk, .rst_n, .in_valid, .in_ready, .in_load_address, .in_load_data,
    .cmd, .stat,
    .a_r(out_a_out), .b_r(out_b_out), .c_r(out_c_out), .d_r(out_d_out),
    .e_r(out_e_out), .h_r(out_h_out), .l_r(out_l_out), .sp_r(out_sp_out),
    .pc_r(out_pc_out), .flag_r(out_flag_bits), .halt_r(out_halted_error)
  );
endmodule

### hw/rtl/c80x_checker.sv
// Port-level checker for the executor, bound to the top level.
// Depends on cpu8080_subset_executor ports only.
module c80x_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_pc_out,
  input logic        out_halted_error
);
  a_excl: assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
    else $error("Input and output both open.");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("Result dropped.");
  a_halt: assert property (@(posedge clk) disable iff (!rst_n)
    out_halted_error && in_ready |=> out_halted_error) else $error("Halt cleared.");
  a_pc: assert property (@(posedge clk) disable iff (!rst_n)
    out_halted_error && in_ready |=> $stable(out_pc_out)) else $error("PC moved while halted.");
endmodule

bind cpu8080_subset_executor c80x_checker u_chk (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_pc_out,
  .out_halted_error
);

### verif/tb_cpu8080_subset_executor.sv
// Testbench for cpu8080_subset_executor: loads short programs, single-steps them and checks
// every machine-state item against an in-bench instruction-set predictor.
// Depends only on the RTL of the executor.
`timescale 1ns / 100ps

module tb_cpu8080_subset_executor;

  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [7:0] OP_NOP = 8'h00, OP_DAA = 8'h27, OP_MOV_MM = 8'h76;
  localparam logic [7:0] OP_LXI_B = 8'h01, OP_LXI_D = 8'h11, OP_LXI_H = 8'h21;
  localparam logic [7:0] OP_LXI_SP = 8'h31, OP_INX_B = 8'h03, OP_DCX_B = 8'h0B;
  localparam logic [7:0] OP_INX_SP = 8'h33, OP_DCX_SP = 8'h3B, OP_MVI_A = 8'h3E;
  localparam logic [7:0] OP_INR_A = 8'h3C, OP_DCR_A = 8'h3D, OP_MVI_M = 8'h36;
  localparam logic [7:0] OP_INR_M = 8'h34, OP_DCR_M = 8'h35, OP_STAX_B = 8'h02;
  localparam logic [7:0] OP_STAX_D = 8'h12, OP_LDAX_B = 8'h0A, OP_LDAX_D = 8'h1A;
  localparam logic [7:0] OP_SHLD = 8'h22, OP_LHLD = 8'h2A, OP_STA = 8'h32;
  localparam logic [7:0] OP_LDA = 8'h3A, OP_RLC = 8'h07, OP_RRC = 8'h0F;
  localparam logic [7:0] OP_RAL = 8'h17, OP_RAR = 8'h1F, OP_CMA = 8'h2F;
  localparam logic [7:0] OP_STC = 8'h37, OP_CMC = 8'h3F, OP_DAD_H = 8'h29;
  localparam logic [7:0] OP_DAD_SP = 8'h39, OP_MOV_AM = 8'h7E, OP_MOV_MA = 8'h77;
  localparam logic [7:0] OP_MOV_BA = 8'h47;
  localparam int R_MEM = 6;
  localparam int P_HL = 2;
  localparam bit KIND_STEP = 1'b0, KIND_LOAD = 1'b1;

  typedef struct packed {
    logic [7:0]  a, b, c, d, e, h, l;
    logic [15:0] sp, pc;
    logic [3:0]  fl;
    logic        hlt;
  } cpu_state_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, in_kind = 1'b0, out_ready = 1'b0;
  logic [15:0] in_load_address = '0;
  logic [7:0] in_load_data = '0;
  logic in_ready, out_valid, out_halted_error;
  logic [7:0] out_a_out, out_b_out, out_c_out, out_d_out, out_e_out, out_h_out, out_l_out;
  logic [15:0] out_sp_out, out_pc_out;
  logic [3:0] out_flag_bits;

  cpu_state_t cpu;
  cpu_state_t expected_states[$];
  logic [7:0] mem_image [0:65535];
  bit mem_written [0:65535];
  int error_count = 0;
  int cycle_count = 0;
  int ready_stall = 0;
  bit no_idle = 1'b0;

  cpu8080_subset_executor dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (ready_stall > 0) begin
      ready_stall <= ready_stall - 1;
      out_ready <= 1'b0;
    end else if (no_idle) begin
      out_ready <= 1'b1;
    end else begin
      if ($urandom_range(0, 99) < 4) ready_stall <= $urandom_range(10, 40);
      out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  function automatic logic [7:0] get_reg(int r);
    case (r)
      0: return cpu.b;
      1: return cpu.c;
      2: return cpu.d;
      3: return cpu.e;
      4: return cpu.h;
      5: return cpu.l;
      R_MEM: return mem_image[{cpu.h, cpu.l}];
      default: return cpu.a;
    endcase
  endfunction

  task automatic put_mem(logic [15:0] adr, logic [7:0] v);
    mem_image[adr] = v;
    mem_written[adr] = 1'b1;
  endtask

  task automatic set_reg(int r, logic [7:0] v);
    case (r)
      0: cpu.b = v;
      1: cpu.c = v;
      2: cpu.d = v;
      3: cpu.e = v;
      4: cpu.h = v;
      5: cpu.l = v;
      R_MEM: put_mem({cpu.h, cpu.l}, v);
      default: cpu.a = v;
    endcase
  endtask

  function automatic logic [15:0] get_pair(int p);
    case (p)
      0: return {cpu.b, cpu.c};
      1: return {cpu.d, cpu.e};
      P_HL: return {cpu.h, cpu.l};
      default: return cpu.sp;
    endcase
  endfunction

  task automatic set_pair(int p, logic [15:0] v);
    case (p)
      0: {cpu.b, cpu.c} = v;
      1: {cpu.d, cpu.e} = v;
      P_HL: {cpu.h, cpu.l} = v;
      default: cpu.sp = v;
    endcase
  endtask

  task automatic set_szp(logic [7:0] v);
    cpu.fl[1] = ~^v;
    cpu.fl[2] = (v == 8'h00);
    cpu.fl[3] = v[7];
  endtask

  task automatic execute_instruction();
    logic [7:0] op, b1, b2, v;
    logic [15:0] imm;
    logic [16:0] sum;
    int r, p, len;
    op = mem_image[cpu.pc];
    b1 = mem_image[cpu.pc + 16'd1];
    b2 = mem_image[cpu.pc + 16'd2];
    imm = {b2, b1};
    r = op[5:3];
    p = op[5:4];
    len = 1;
    if (op == OP_DAA || op[7]) begin
      cpu.hlt = 1'b1;
      return;
    end
    if (op[6]) begin
      if (op != OP_MOV_MM) set_reg(r, get_reg(op[2:0]));
    end else begin
      case (op[2:0])
        3'd1: begin
          if (op[3]) begin
            sum = {1'b0, get_pair(P_HL)} + {1'b0, get_pair(p)};
            set_pair(P_HL, sum[15:0]);
            cpu.fl[0] = sum[16];
          end else begin
            set_pair(p, imm);
            len = 3;
          end
        end
        3'd2: begin
          case (op)
            OP_STAX_B: put_mem(get_pair(0), cpu.a);
            OP_STAX_D: put_mem(get_pair(1), cpu.a);
            OP_LDAX_B: cpu.a = mem_image[get_pair(0)];
            OP_LDAX_D: cpu.a = mem_image[get_pair(1)];
            OP_SHLD: begin
              put_mem(imm, cpu.l);
              put_mem(imm + 16'd1, cpu.h);
            end
            OP_LHLD: begin
              cpu.l = mem_image[imm];
              cpu.h = mem_image[imm + 16'd1];
            end
            OP_STA: put_mem(imm, cpu.a);
            default: cpu.a = mem_image[imm];
          endcase
          if (op[5]) len = 3;
        end
        3'd3: set_pair(p, get_pair(p) + (op[3] ? 16'hFFFF : 16'd1));
        3'd4: begin
          v = get_reg(r) + 8'd1;
          set_reg(r, v);
          set_szp(v);
        end
        3'd5: begin
          v = get_reg(r) - 8'd1;
          set_reg(r, v);
          set_szp(v);
        end
        3'd6: begin
          set_reg(r, b1);
          len = 2;
        end
        3'd7: begin
          case (op)
            OP_RLC: begin
              cpu.fl[0] = cpu.a[7];
              cpu.a = {cpu.a[6:0], cpu.a[7]};
            end
            OP_RRC: begin
              cpu.fl[0] = cpu.a[0];
              cpu.a = {cpu.a[0], cpu.a[7:1]};
            end
            OP_RAL: {cpu.fl[0], cpu.a} = {cpu.a, cpu.fl[0]};
            OP_RAR: {cpu.a, cpu.fl[0]} = {cpu.fl[0], cpu.a};
            OP_CMA: cpu.a = ~cpu.a;
            OP_STC: cpu.fl[0] = 1'b1;
            default: cpu.fl[0] = ~cpu.fl[0];
          endcase
        end
        default: ;
      endcase
    end
    cpu.pc = cpu.pc + 16'(len);
  endtask

  task automatic send_item(bit kind, logic [15:0] adr, logic [7:0] data);
    int gap, pick;
    pick = $urandom_range(0, 99);
    gap = no_idle ? 0 : (pick < 60) ? 0 : (pick < 95) ? $urandom_range(1, 3)
                                                       : $urandom_range(10, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_load_address <= adr;
    in_load_data <= data;
    if (kind == KIND_LOAD) put_mem(adr, data);
    else if (!cpu.hlt) execute_instruction();
    expected_states.push_back(cpu);
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic fill_if_unwritten(logic [15:0] adr);
    if (!mem_written[adr]) send_item(KIND_LOAD, adr, 8'($urandom));
  endtask

  // Places the instruction at the program counter, supplies any data byte that it will read,
  // then steps it.
  task automatic run_op(logic [7:0] op, logic [7:0] b1 = 8'($urandom),
                        logic [7:0] b2 = 8'($urandom));
    logic [15:0] imm;
    imm = {b2, b1};
    send_item(KIND_LOAD, cpu.pc, op);
    send_item(KIND_LOAD, cpu.pc + 16'd1, b1);
    send_item(KIND_LOAD, cpu.pc + 16'd2, b2);
    if ((op[7:6] == 2'b01 && op[2:0] == R_MEM && op != OP_MOV_MM) ||
        (op[7:6] == 2'b00 && op[5:3] == R_MEM && (op[2:0] == 3'd4 || op[2:0] == 3'd5)))
      fill_if_unwritten({cpu.h, cpu.l});
    if (op == OP_LDAX_B) fill_if_unwritten({cpu.b, cpu.c});
    if (op == OP_LDAX_D) fill_if_unwritten({cpu.d, cpu.e});
    if (op == OP_LDA || op == OP_LHLD) fill_if_unwritten(imm);
    if (op == OP_LHLD) fill_if_unwritten(imm + 16'd1);
    send_item(KIND_STEP, 16'($urandom), 8'($urandom));
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_states.size() != 0) @(posedge clk);
  endtask

  task automatic compare_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    cpu_state_t exp_s;
    if (rst_n && out_valid && out_ready) begin
      if (expected_states.size() == 0) begin
        $error("result item with no expected state waiting");
        error_count++;
      end else begin
        exp_s = expected_states.pop_front();
        compare_field("a_out", exp_s.a, out_a_out);
        compare_field("b_out", exp_s.b, out_b_out);
        compare_field("c_out", exp_s.c, out_c_out);
        compare_field("d_out", exp_s.d, out_d_out);
        compare_field("e_out", exp_s.e, out_e_out);
        compare_field("h_out", exp_s.h, out_h_out);
        compare_field("l_out", exp_s.l, out_l_out);
        compare_field("sp_out", exp_s.sp, out_sp_out);
        compare_field("pc_out", exp_s.pc, out_pc_out);
        compare_field("flag_bits", exp_s.fl, out_flag_bits);
        compare_field("halted_error", exp_s.hlt, out_halted_error);
      end
    end
  end

  task automatic test_directed_ops();
    send_item(KIND_LOAD, 16'hFFFF, 8'hFF);
    send_item(KIND_LOAD, 16'h0000, 8'h00);
    run_op(OP_NOP);
    run_op(OP_LXI_B, 8'hFF, 8'hFF);
    run_op(OP_LXI_D, 8'h00, 8'h00);
    run_op(OP_LXI_H, 8'hFF, 8'h80);
    run_op(OP_LXI_SP, 8'hFF, 8'hFF);
    run_op(OP_INX_SP);
    run_op(OP_DCX_SP);
    run_op(OP_INX_B);
    run_op(OP_DCX_B);
    run_op(OP_MVI_A, 8'hFF);
    run_op(OP_INR_A);
    run_op(OP_DCR_A);
    run_op(OP_MVI_M, 8'h7F);
    run_op(OP_INR_M);
    run_op(OP_DCR_M);
    run_op(OP_STAX_B);
    run_op(OP_STAX_D);
    run_op(OP_LDAX_B);
    run_op(OP_LDAX_D);
    run_op(OP_STC);
    run_op(OP_RAR);
    run_op(OP_RAL);
    run_op(OP_RLC);
    run_op(OP_RRC);
    run_op(OP_CMC);
    run_op(OP_CMA);
    run_op(OP_DAD_H);
    run_op(OP_DAD_SP);
    run_op(OP_SHLD, 8'hFF, 8'hFF);
    run_op(OP_LHLD, 8'hFF, 8'hFF);
    run_op(OP_STA, 8'h00, 8'hC0);
    run_op(OP_LDA, 8'h00, 8'hC0);
    run_op(OP_MOV_MM);
    run_op(OP_MOV_AM);
    run_op(OP_MOV_MA);
    run_op(OP_MOV_BA);
  endtask

  task automatic test_random_program();
    logic [7:0] op;
    for (int i = 0; i < 160; i++) begin
      if (i == 60) wait_for_results();
      no_idle = (i >= 100 && i < 130);
      if ($urandom_range(0, 9) < 2) begin
        send_item(KIND_LOAD, 16'($urandom), 8'($urandom));
      end else begin
        do op = 8'($urandom_range(0, 127)); while (op == OP_DAA);
        run_op(op);
      end
    end
    no_idle = 1'b0;
  endtask

  // Only one halt is possible per run, so this comes last.
  task automatic test_halt();
    run_op(($urandom_range(0, 1) != 0) ? OP_DAA : 8'($urandom_range(128, 255)));
    for (int i = 0; i < 20; i++) begin
      send_item(KIND_STEP, 16'($urandom), 8'($urandom));
      send_item(KIND_LOAD, 16'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    cpu = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_ops();
    test_random_program();
    test_halt();
    wait_for_results();
    repeat (40) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
